FILE: sv/evag_pkg.sv
package evag_pkg;

  localparam int FRAME_MAX_DEF = 1024;

  // fixed widths of the Q1.24 datapath
  localparam int SQ_W   = 31;   // square of a 16-bit sample
  localparam int QUO_W  = 49;   // mean << 18, at most 2^48
  localparam int LVL_W  = 25;   // Q1.24 level, 0..2^24
  localparam int LINE_W = 27;   // threshold before saturation
  localparam int COEF_W = 24;
  localparam int PROD_W = LINE_W + COEF_W;
  localparam int SQRT_STEPS = (QUO_W + 1) / 2;

  localparam logic [COEF_W-1:0] ATTACK_C     = 24'd10066330;
  localparam logic [COEF_W-1:0] DECAY_C      = 24'd3355443;
  localparam logic [COEF_W-1:0] FLOOR_DOWN_C = 24'd2516582;
  localparam logic [COEF_W-1:0] FLOOR_UP_C   = 24'd13422;
  localparam logic [COEF_W-1:0] CLOSE_C      = 24'd10905190;
  localparam logic [LINE_W-1:0] LINE_MIN     = 27'd67109;
  localparam logic [LVL_W-1:0]  FLOOR_RESET  = 25'd335544;
  localparam logic [14:0]       MANUAL_MAX   = 15'd16384;

  localparam int PADDR_W = 4;
  typedef enum logic [1:0] {
    REG_GATE_ENABLED   = 2'd0,
    REG_AUTOMATIC_MODE = 2'd1,
    REG_MANUAL_THR     = 2'd2,
    REG_HOLD_SPAN      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        gate_enabled;
    logic        automatic_mode;
    logic [14:0] manual_threshold;
    logic [5:0]  hold_span;
    logic        disable_pulse;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_ENV   = 2'd0,
    MUL_FLOOR = 2'd1,
    MUL_CLOSE = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     acc_add;
    logic     div_load;
    logic     div_step;
    logic     sqrt_load;
    logic     sqrt_step;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     env_upd;
    logic     floor_upd;
    logic     decide;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic out_free;
  } status_t;

  function automatic logic [15:0] to_q15(input logic [LINE_W-1:0] v);
    logic [LINE_W:0] r;
    r = {1'b0, v} + (LINE_W+1)'(256);
    if (r[LINE_W:9] > (LINE_W-8)'(32768)) to_q15 = 16'd32768;
    else to_q15 = r[24:9];
  endfunction

endpackage

FILE: sv/evag_if.sv
interface evag_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               frame_end;
  modport source(output valid, sample, frame_end, input ready);
  modport sink(input valid, sample, frame_end, output ready);
endinterface

interface evag_out_if;
  logic        valid;
  logic        ready;
  logic        speaking;
  logic        gate_open;
  logic [15:0] frame_level;
  logic [15:0] threshold_level;
  modport source(output valid, speaking, gate_open, frame_level, threshold_level,
                 input ready);
  modport sink(input valid, speaking, gate_open, frame_level, threshold_level,
               output ready);
endinterface

FILE: sv/energy_voice_activity_gate_top.sv
// channel   dir  payload                                            transfer
// samples   in   sample[15:0] signed, frame_end                     valid & ready
// results   out  speaking, gate_open, frame_level, threshold_level  valid & ready
// apb       in   gate_enabled, automatic_mode, manual_threshold,    psel & penable
//                hold span at 0x0/0x4/0x8/0xC                        & pwrite
//
// A sample is squared, then accumulated; the next sample is accepted only after that.
// A frame_end sample then goes through a divider load, the bit-serial divider,
// a root load, the bit-serial root, then the envelope, floor and close steps
// and the decision; the smoothing steps share one multiplier.
// rst is synchronous, active high, and restores the register defaults and state.
// A result waits in the output register while samples keep flowing; the next
// frame end stalls at its decision until that result is taken.
module energy_voice_activity_gate_top #(
  parameter int FRAME_MAX = evag_pkg::FRAME_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  evag_in_if.sink                      samples,
  evag_out_if.source                   results,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [evag_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  evag_pkg::cfg_t    cfg;
  evag_pkg::cmd_t    cmd;
  evag_pkg::status_t st;

  evag_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  evag_ctrl #(.FRAME_MAX(FRAME_MAX)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .st       (st),
    .cmd      (cmd)
  );

  evag_dp #(.FRAME_MAX(FRAME_MAX)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg             (cfg),
    .st              (st),
    .sample          (samples.sample),
    .frame_end       (samples.frame_end),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .speaking        (results.speaking),
    .gate_open       (results.gate_open),
    .frame_level     (results.frame_level),
    .threshold_level (results.threshold_level)
  );

endmodule

FILE: sv/evag_regs.sv
module evag_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [evag_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output evag_pkg::cfg_t               cfg
);

  logic                  gate_enabled;
  logic                  automatic_mode;
  logic [14:0]           manual_threshold;
  logic [5:0]            hold_span;
  logic                  disable_pulse;
  logic                  wr;
  evag_pkg::reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = evag_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_enabled     <= 1'b1;
      automatic_mode   <= 1'b1;
      manual_threshold <= 15'd655;
      hold_span        <= 6'd15;
      disable_pulse    <= 1'b0;
    end else begin
      disable_pulse <= 1'b0;
      if (wr) begin
        unique case (idx)
          evag_pkg::REG_GATE_ENABLED: begin
            disable_pulse <= gate_enabled & ~pwdata[0];
            gate_enabled  <= pwdata[0];
          end
          evag_pkg::REG_AUTOMATIC_MODE: automatic_mode <= pwdata[0];
          evag_pkg::REG_MANUAL_THR: begin
            if (pwdata[14:0] > evag_pkg::MANUAL_MAX) manual_threshold <= evag_pkg::MANUAL_MAX;
            else manual_threshold <= pwdata[14:0];
          end
          evag_pkg::REG_HOLD_SPAN: hold_span <= pwdata[5:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      evag_pkg::REG_GATE_ENABLED:   prdata = {31'd0, gate_enabled};
      evag_pkg::REG_AUTOMATIC_MODE: prdata = {31'd0, automatic_mode};
      evag_pkg::REG_MANUAL_THR:     prdata = {17'd0, manual_threshold};
      evag_pkg::REG_HOLD_SPAN:      prdata = {26'd0, hold_span};
      default:                      prdata = 32'd0;
    endcase
  end

  assign cfg = '{gate_enabled:     gate_enabled,
                 automatic_mode:   automatic_mode,
                 manual_threshold: manual_threshold,
                 hold_span:        hold_span,
                 disable_pulse:    disable_pulse};

endmodule

FILE: sv/evag_ctrl.sv
module evag_ctrl #(
  parameter int FRAME_MAX = evag_pkg::FRAME_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  evag_pkg::status_t st,
  output evag_pkg::cmd_t    cmd
);

  localparam int SUM_W = evag_pkg::SQ_W + $clog2(FRAME_MAX);
  localparam int NUM_W = SUM_W + 18;
  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_LOAD, S_DIV, S_SQ_LOAD, S_SQRT,
    S_ENV_MUL, S_ENV_UPD, S_FLR_MUL, S_FLR_UPD, S_CL_MUL, S_DECIDE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE:    if (in_valid) state <= S_ACC;
        S_ACC:     state <= st.frame_end ? S_LOAD : S_IDLE;
        S_LOAD: begin
          state <= S_DIV;
          cnt   <= CNT_W'(NUM_W - 1);
        end
        S_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= S_SQ_LOAD;
        end
        S_SQ_LOAD: begin
          state <= S_SQRT;
          cnt   <= CNT_W'(evag_pkg::SQRT_STEPS - 1);
        end
        S_SQRT: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= S_ENV_MUL;
        end
        S_ENV_MUL: state <= S_ENV_UPD;
        S_ENV_UPD: state <= S_FLR_MUL;
        S_FLR_MUL: state <= S_FLR_UPD;
        S_FLR_UPD: state <= S_CL_MUL;
        S_CL_MUL:  state <= S_DECIDE;
        S_DECIDE:  if (st.out_free) state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = evag_pkg::MUL_ENV;
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.acc_add   = (state == S_ACC);
    cmd.div_load  = (state == S_LOAD);
    cmd.div_step  = (state == S_DIV);
    cmd.sqrt_load = (state == S_SQ_LOAD);
    cmd.sqrt_step = (state == S_SQRT);
    cmd.env_upd   = (state == S_ENV_UPD);
    cmd.floor_upd = (state == S_FLR_UPD);
    cmd.decide    = (state == S_DECIDE) && st.out_free;
    cmd.mul_en    = (state == S_ENV_MUL) || (state == S_FLR_MUL) || (state == S_CL_MUL);
    if (state == S_FLR_MUL) cmd.mul_sel = evag_pkg::MUL_FLOOR;
    else if (state == S_CL_MUL) cmd.mul_sel = evag_pkg::MUL_CLOSE;
  end

endmodule

FILE: sv/evag_dp.sv
module evag_dp #(
  parameter int FRAME_MAX = evag_pkg::FRAME_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  evag_pkg::cmd_t     cmd,
  input  evag_pkg::cfg_t     cfg,
  output evag_pkg::status_t  st,
  input  logic signed [15:0] sample,
  input  logic               frame_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               speaking,
  output logic               gate_open,
  output logic [15:0]        frame_level,
  output logic [15:0]        threshold_level
);

  localparam int SUM_W = evag_pkg::SQ_W + $clog2(FRAME_MAX);
  localparam int NUM_W = SUM_W + 18;
  localparam int FC_W  = $clog2(FRAME_MAX + 1);
  localparam int LW    = evag_pkg::LVL_W;
  localparam int QW    = evag_pkg::QUO_W;
  localparam int NL_W  = evag_pkg::LINE_W;
  localparam int PW    = evag_pkg::PROD_W;

  // accumulation
  logic [evag_pkg::SQ_W-1:0] sq;
  logic                      fe;
  logic [SUM_W-1:0]          square_sum;
  logic [FC_W-1:0]           sample_count;
  logic signed [31:0]        sq_full;

  assign sq_full = sample * sample;

  // bit-serial divider
  logic [NUM_W-1:0] num;
  logic [FC_W-1:0]  den;
  logic [FC_W-1:0]  rem;
  logic [FC_W:0]    trial;
  logic             fits;

  assign trial = {rem, num[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  // bit-serial square root
  logic [QW-1:0] sv;
  logic [QW-1:0] sr;
  logic [QW-1:0] sbit;
  logic [QW-1:0] sr_bit;
  logic [LW-1:0] rms;

  assign sr_bit = sr + sbit;
  assign rms    = sr[LW-1:0];

  // level tracking
  logic [LW-1:0]   envelope;
  logic [LW-1:0]   noise_floor;
  logic            open_flag;
  logic [5:0]      hold_count;
  logic [NL_W-1:0] line;
  logic [NL_W-1:0] line_c;
  logic [NL_W-1:0] line_auto;
  logic [NL_W+2:0] floor7;
  logic [PW-1:0]   prod;
  logic [PW:0]     rnd;
  logic [NL_W-1:0] step;
  logic [NL_W-1:0] mul_a;
  logic [evag_pkg::COEF_W-1:0] mul_b;

  assign rnd  = {1'b0, prod} + (PW+1)'(1 << 23);
  assign step = rnd[NL_W+23:24];

  assign floor7    = ({2'b0, noise_floor, 3'b0} - {5'b0, noise_floor}) + (NL_W+3)'(1);
  assign line_auto = floor7[NL_W:1];
  always_comb begin
    if (!cfg.automatic_mode) line_c = NL_W'({cfg.manual_threshold, 9'd0});
    else if (line_auto < evag_pkg::LINE_MIN) line_c = evag_pkg::LINE_MIN;
    else line_c = line_auto;
  end

  always_comb begin
    unique case (cmd.mul_sel)
      evag_pkg::MUL_ENV: begin
        mul_a = (rms > envelope) ? NL_W'(rms - envelope) : NL_W'(envelope - rms);
        mul_b = (rms > envelope) ? evag_pkg::ATTACK_C : evag_pkg::DECAY_C;
      end
      evag_pkg::MUL_FLOOR: begin
        mul_a = (rms >= noise_floor) ? NL_W'(rms - noise_floor) : NL_W'(noise_floor - rms);
        mul_b = (rms < noise_floor) ? evag_pkg::FLOOR_DOWN_C : evag_pkg::FLOOR_UP_C;
      end
      evag_pkg::MUL_CLOSE: begin
        mul_a = line_c;
        mul_b = evag_pkg::CLOSE_C;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // gate decision
  logic       spk_c;
  logic       open_c;
  logic [5:0] hold_c;

  always_comb begin
    spk_c  = 1'b1;
    open_c = open_flag;
    hold_c = hold_count;
    priority if (!cfg.gate_enabled) begin
      open_c = 1'b1;
    end else if (NL_W'(envelope) >= line) begin
      open_c = 1'b1;
      hold_c = cfg.hold_span;
    end else if (open_flag && NL_W'(envelope) >= step) begin
      hold_c = cfg.hold_span;
    end else if (hold_count != '0) begin
      hold_c = hold_count - 1'b1;
    end else begin
      open_c = 1'b0;
      spk_c  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sq <= sq_full[evag_pkg::SQ_W-1:0];
      fe <= frame_end;
    end
    if (cmd.div_load) begin
      num <= {square_sum, 18'd0};
      den <= sample_count;
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= fits ? FC_W'(trial - {1'b0, den}) : trial[FC_W-1:0];
      num <= {num[NUM_W-2:0], fits};
    end
    if (cmd.sqrt_load) begin
      sv   <= num[QW-1:0];
      sr   <= '0;
      sbit <= QW'(1) << (QW - 1);
    end else if (cmd.sqrt_step) begin
      if (sv >= sr_bit) begin
        sv <= sv - sr_bit;
        sr <= (sr >> 1) + sbit;
      end else begin
        sr <= sr >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (cmd.mul_en) begin
      prod <= {{evag_pkg::COEF_W{1'b0}}, mul_a} * {{NL_W{1'b0}}, mul_b};
      if (cmd.mul_sel == evag_pkg::MUL_CLOSE) line <= line_c;
    end
    if (cmd.decide) begin
      speaking        <= spk_c;
      gate_open       <= open_c;
      frame_level     <= evag_pkg::to_q15(NL_W'(rms));
      threshold_level <= evag_pkg::to_q15(line);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_count <= '0;
      envelope     <= '0;
      noise_floor  <= evag_pkg::FLOOR_RESET;
      open_flag    <= 1'b0;
      hold_count   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.div_load) begin
        square_sum   <= '0;
        sample_count <= '0;
      end else if (cmd.acc_add && sample_count < FC_W'(FRAME_MAX)) begin
        square_sum   <= square_sum + SUM_W'(sq);
        sample_count <= sample_count + 1'b1;
      end
      if (cmd.env_upd) begin
        if (rms > envelope) envelope <= envelope + step[LW-1:0];
        else envelope <= envelope - step[LW-1:0];
      end
      if (cmd.floor_upd && cfg.automatic_mode) begin
        if (rms >= noise_floor) noise_floor <= noise_floor + step[LW-1:0];
        else noise_floor <= noise_floor - step[LW-1:0];
      end
      if (cfg.disable_pulse) begin
        open_flag  <= 1'b1;
        hold_count <= '0;
      end else if (cmd.decide) begin
        open_flag  <= open_c;
        hold_count <= hold_c;
      end
      if (cmd.decide) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign st = '{frame_end: fe, out_free: ~out_valid | out_ready};

endmodule

FILE: sim/energy_voice_activity_gate_top_tb.sv
module energy_voice_activity_gate_top_tb;
  import evag_pkg::*;

  localparam int LIMIT     = 1000000;
  localparam int DRAIN     = 120;  // margin for the frame-end processing
  localparam int FRAME_CAP = 1024;

  typedef struct {
    bit        speaking;
    bit        gate_open;
    bit [15:0] level;
    bit [15:0] thr;
  } verdict_t;

  typedef enum bit {ROW_FRAME, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    reg_idx_t           idx;
    bit [31:0]          value;
    bit signed [15:0]   smp;
    int                 len;
    bit                 typed;
    verdict_t           want;
  } row_t;

  logic clk = 0;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  evag_in_if  smp_ch();
  evag_out_if res_ch();

  energy_voice_activity_gate_top uut (
    .clk(clk), .rst(rst), .samples(smp_ch.sink), .results(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // mirror of the registers and datapath state
  bit        cfg_en, cfg_auto;
  bit [14:0] cfg_man;
  bit [5:0]  cfg_hold;
  longint unsigned energy_acc;
  int unsigned     energy_cnt;
  longint unsigned env_q24, floor_q24;
  bit              open_q;
  int unsigned     hold_q;

  verdict_t pending[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  row_t script[24];

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned glide(longint unsigned cur, longint unsigned tgt,
                                            longint unsigned c);
    longint unsigned d, st;
    d  = (tgt >= cur) ? tgt - cur : cur - tgt;
    st = (d * c + 64'd8388608) >> 24;
    return (tgt >= cur) ? cur + st : cur - st;
  endfunction

  function automatic bit [15:0] level_q15(longint unsigned q24);
    longint unsigned v;
    v = (q24 + 256) >> 9;
    return (v > 32768) ? 16'd32768 : v[15:0];
  endfunction

  // one accepted sample; returns 1 and fills v when it closes a frame
  function automatic bit frame_verdict(bit signed [15:0] s, bit fe, output verdict_t v);
    longint signed   sv;
    longint unsigned lvl, thr, close_thr;
    bit              speak;
    sv = s;
    if (energy_cnt < FRAME_CAP) begin
      energy_acc += longint'(sv * sv);
      energy_cnt++;
    end
    if (!fe) return 0;
    lvl = (energy_cnt != 0) ? root64((energy_acc << 18) / energy_cnt) : 0;
    if (lvl > 64'd16777216) lvl = 64'd16777216;
    energy_acc = 0;
    energy_cnt = 0;
    env_q24 = glide(env_q24, lvl, (lvl > env_q24) ? ATTACK_C : DECAY_C);
    if (cfg_auto) begin
      floor_q24 = glide(floor_q24, lvl, (lvl < floor_q24) ? FLOOR_DOWN_C : FLOOR_UP_C);
      thr = (floor_q24 * 7 + 1) >> 1;
      if (thr < LINE_MIN) thr = LINE_MIN;
    end else begin
      thr = longint'(cfg_man) << 9;
    end
    if (!cfg_en) begin
      open_q = 1;
      speak = 1;
    end else if (env_q24 >= thr) begin
      open_q = 1;
      hold_q = cfg_hold;
      speak = 1;
    end else begin
      close_thr = (thr * CLOSE_C + 64'd8388608) >> 24;
      if (open_q && env_q24 >= close_thr) begin
        hold_q = cfg_hold;
        speak = 1;
      end else if (hold_q > 0) begin
        hold_q--;
        speak = 1;
      end else begin
        open_q = 0;
        speak = 0;
      end
    end
    v.speaking  = speak;
    v.gate_open = open_q;
    v.level     = level_q15(lvl);
    v.thr       = level_q15(thr);
    return 1;
  endfunction

  task automatic wait_idle();
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, bit [31:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel    <= 0;
    penable <= 0;
    case (idx)
      REG_GATE_ENABLED: begin
        if (cfg_en && !val[0]) begin
          open_q = 1;
          hold_q = 0;
        end
        cfg_en = val[0];
      end
      REG_AUTOMATIC_MODE: cfg_auto = val[0];
      REG_MANUAL_THR:     cfg_man = (val[14:0] > MANUAL_MAX) ? MANUAL_MAX : val[14:0];
      REG_HOLD_SPAN:      cfg_hold = val[5:0];
    endcase
  endtask

  task automatic send_sample(bit signed [15:0] s, bit fe, bit typed, verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < idle_pct) begin
      smp_ch.valid <= 0;
      @(posedge clk);
    end
    smp_ch.valid     <= 1;
    smp_ch.sample    <= s;
    smp_ch.frame_end <= fe;
    do @(posedge clk); while (!smp_ch.ready);
    if (frame_verdict(s, fe, v)) pending.push_back(typed ? want : v);
  endtask

  task automatic random_frame(int len, int style);
    bit signed [15:0] s;
    verdict_t none;
    none = '{0, 0, 0, 0};
    for (int i = 0; i < len; i++) begin
      case (style)
        0:       s = $signed(16'($urandom_range(80))) - 16'sd40;
        1:       s = $signed(16'($urandom_range(4000))) - 16'sd2000;
        default: s = 16'($urandom);
      endcase
      send_sample(s, i == len - 1, 0, none);
    end
  endtask

  task automatic random_phase(int n_items);
    int sent, len, style;
    sent = 0;
    style = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
      // runs of quiet and loud frames drive the gate through open, hold and close
      if ($urandom_range(3) == 0) style = $urandom_range(2);
      random_frame(len, style);
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    if (rst) res_ch.ready <= 0;
    else res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending.size() == 0) begin
        $display("%0t unexpected result transfer", $time);
        errors++;
      end else begin
        verdict_t e;
        e = pending.pop_front();
        if (res_ch.speaking !== e.speaking) begin
          $display("%0t speaking exp %0d got %0d", $time, e.speaking, res_ch.speaking);
          errors++;
        end
        if (res_ch.gate_open !== e.gate_open) begin
          $display("%0t gate_open exp %0d got %0d", $time, e.gate_open, res_ch.gate_open);
          errors++;
        end
        if (res_ch.frame_level !== e.level) begin
          $display("%0t frame_level exp %0d got %0d", $time, e.level, res_ch.frame_level);
          errors++;
        end
        if (res_ch.threshold_level !== e.thr) begin
          $display("%0t threshold_level exp %0d got %0d", $time, e.thr,
                   res_ch.threshold_level);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    verdict_t none;
    none = '{0, 0, 0, 0};
    script[0]  = '{ROW_FRAME, REG_GATE_ENABLED, 0, 16'sd0, 1, 0, none};
    script[1]  = '{ROW_FRAME, REG_GATE_ENABLED, 0, 16'sd32767, 4, 0, none};
    script[2]  = '{ROW_FRAME, REG_GATE_ENABLED, 0, -16'sd32768, 3, 0, none};
    script[3]  = '{ROW_FRAME, REG_GATE_ENABLED, 0, 16'sd1, 2, 0, none};
    script[4]  = '{ROW_CFG, REG_GATE_ENABLED, 0, 16'sd0, 0, 0, none};
    script[5]  = '{ROW_CFG, REG_AUTOMATIC_MODE, 0, 16'sd0, 0, 0, none};
    script[6]  = '{ROW_CFG, REG_MANUAL_THR, 32'h7FFF, 16'sd0, 0, 0, none};
    script[7]  = '{ROW_FRAME, REG_GATE_ENABLED, 0, -16'sd32768, 2, 1,
                   '{1, 1, 16'd32768, 16'd16384}};
    script[8]  = '{ROW_FRAME, REG_GATE_ENABLED, 0, 16'sd0, 1, 1, '{1, 1, 16'd0, 16'd16384}};
    script[9]  = '{ROW_CFG, REG_MANUAL_THR, 0, 16'sd0, 0, 0, none};
    script[10] = '{ROW_FRAME, REG_GATE_ENABLED, 0, 16'sd0, 1, 1, '{1, 1, 16'd0, 16'd0}};
    script[11] = '{ROW_CFG, REG_GATE_ENABLED, 0, 16'sd0, 0, 0, none};
    script[12] = '{ROW_CFG, REG_GATE_ENABLED, 1, 16'sd0, 0, 0, none};
    script[13] = '{ROW_CFG, REG_HOLD_SPAN, 0, 16'sd0, 0, 0, none};
    script[14] = '{ROW_CFG, REG_MANUAL_THR, 16384, 16'sd0, 0, 0, none};
    script[15] = '{ROW_FRAME, REG_GATE_ENABLED, 0, 16'sd0, 2, 0, none};
    script[16] = '{ROW_FRAME, REG_GATE_ENABLED, 0, -16'sd32768, 2, 0, none};
    script[17] = '{ROW_CFG, REG_HOLD_SPAN, 63, 16'sd0, 0, 0, none};
    script[18] = '{ROW_FRAME, REG_GATE_ENABLED, 0, 16'sd0, 1, 0, none};
    script[19] = '{ROW_FRAME, REG_GATE_ENABLED, 0, 16'sd0, 1, 0, none};
    script[20] = '{ROW_CFG, REG_AUTOMATIC_MODE, 1, 16'sd0, 0, 0, none};
    script[21] = '{ROW_CFG, REG_HOLD_SPAN, 15, 16'sd0, 0, 0, none};
    script[22] = '{ROW_FRAME, REG_GATE_ENABLED, 0, 16'sd21845, 2, 0, none};
    script[23] = '{ROW_FRAME, REG_GATE_ENABLED, 0, -16'sd21846, 2, 0, none};

    cfg_en = 1; cfg_auto = 1; cfg_man = 655; cfg_hold = 15;
    energy_acc = 0; energy_cnt = 0; env_q24 = 0; floor_q24 = FLOOR_RESET;
    open_q = 0; hold_q = 0;

    rst <= 1;
    psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
    smp_ch.valid <= 0; smp_ch.sample <= 0; smp_ch.frame_end <= 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        smp_ch.valid <= 0;
        wait_idle();
        reg_write(script[r].idx, script[r].value);
      end else begin
        for (int i = 0; i < script[r].len; i++)
          send_sample(script[r].smp, i == script[r].len - 1, script[r].typed, script[r].want);
      end
    end
    smp_ch.valid <= 0;

    // one overlong frame: samples past the cap are dropped
    wait_idle();
    random_frame(1030, 2);
    random_phase(130);

    // receiver stall, manual threshold at its maximum or a random low value, no hold
    smp_ch.valid <= 0;
    wait_idle();
    stall_pct = 60;
    reg_write(REG_AUTOMATIC_MODE, 0);
    reg_write(REG_MANUAL_THR, $urandom_range(1) ? 32'h7FFF : $urandom_range(1200, 1));
    reg_write(REG_HOLD_SPAN, 0);
    random_phase(130);

    // sender idling, gate disabled, longest hold
    smp_ch.valid <= 0;
    wait_idle();
    stall_pct = 0;
    idle_pct = 60;
    reg_write(REG_GATE_ENABLED, 0);
    reg_write(REG_HOLD_SPAN, 63);
    random_phase(130);

    // both sides idle, automatic again
    smp_ch.valid <= 0;
    wait_idle();
    stall_pct = 26;
    idle_pct = 26;
    reg_write(REG_GATE_ENABLED, 1);
    reg_write(REG_AUTOMATIC_MODE, 1);
    reg_write(REG_HOLD_SPAN, $urandom_range(63));
    random_phase(130);
    smp_ch.valid <= 0;

    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
